### src/tcfla_pkg.sv
package tcfla_pkg;

   // Pool sizes. Slots below SMALL_SLOTS form the small pool, the rest the large pool.
   localparam int SMALL_SLOTS = 240;
   localparam int LARGE_SLOTS = 16;
   localparam int TOTAL_SLOTS = SMALL_SLOTS + LARGE_SLOTS;

   // A slot index addresses the link store; a link can also hold the null code.
   localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int LINK_W = $clog2(TOTAL_SLOTS + 1);
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(TOTAL_SLOTS);

   // Link store entry: in-use mark above the next link.
   localparam int ENTRY_W = LINK_W + 1;

   localparam int LIMIT_W = 16;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   localparam logic CSR_SMALL_LIMIT = 1'b0;
   localparam logic CSR_LARGE_LIMIT = 1'b1;

   localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RESET = 16'd32;
   localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RESET = 16'd256;

   typedef struct packed {
      logic [1:0]         command;
      logic [LIMIT_W-1:0] request_size;
      logic [7:0]         slot_to_free;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_slot;
      logic       from_large_pool;
   } rsp_type;

endpackage

### src/two_class_free_list_allocator.sv
// Two-class slot allocator. A command item is taken when start is high and busy is
// low; its result appears on rsp_item for exactly one cycle with rsp_strobe high and
// cannot be held off, so the receiver must take it then. For allocate, free and the unused
// command the link store is read in the cycle the item is taken and written back in
// the next, and the result strobe overlaps the following item. Init walks the link
// store one slot a cycle. After reset the pools are empty until an init is run. The
// size limits may be written only while busy is low and no result is pending.
module two_class_free_list_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  tcfla_pkg::req_type           req_item,
   output logic                         rsp_strobe,
   output tcfla_pkg::rsp_type           rsp_item,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [tcfla_pkg::LIMIT_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_INIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [tcfla_pkg::LIMIT_W-1:0]     small_limit_ff, small_limit_in;
   logic [tcfla_pkg::LIMIT_W-1:0]     large_limit_ff, large_limit_in;
   logic [tcfla_pkg::LINK_W-1:0]      small_head_ff, small_head_in;
   logic [tcfla_pkg::LINK_W-1:0]      large_head_ff, large_head_in;
   logic [tcfla_pkg::LINK_W-1:0]      alloc_head_ff, alloc_head_in;
   logic [tcfla_pkg::TOTAL_SLOTS-1:0] valid_ff, valid_in;
   logic [tcfla_pkg::SLOT_W-1:0]      count_ff, count_in;
   tcfla_pkg::req_type                req_ff, req_in;
   logic [tcfla_pkg::SLOT_W-1:0]      addr_ff, addr_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   tcfla_pkg::rsp_type                rsp_ff, rsp_in;

   logic                              accept;
   logic                              use_large_now;
   logic [tcfla_pkg::LINK_W-1:0]      chosen_head_now;
   logic                              rd_en;
   logic [tcfla_pkg::SLOT_W-1:0]      rd_addr;
   logic [tcfla_pkg::ENTRY_W-1:0]     rd_data;
   logic                              wr_en;
   logic [tcfla_pkg::SLOT_W-1:0]      wr_addr;
   logic [tcfla_pkg::ENTRY_W-1:0]     wr_data;

   logic                              entry_valid;
   logic [tcfla_pkg::LINK_W-1:0]      entry_link;
   logic                              entry_in_use;
   logic                              use_large;
   logic [tcfla_pkg::LIMIT_W-1:0]     limit;
   logic [tcfla_pkg::LINK_W-1:0]      head;
   logic                              slot_in_range;
   logic                              slot_is_large;

   assign accept = start && (state_ff == S_IDLE);

   // The read address is chosen from the incoming item so that the entry is ready
   // in the following cycle.
   assign use_large_now   = req_item.request_size > small_limit_ff;
   assign chosen_head_now = use_large_now ? large_head_ff : small_head_ff;
   assign rd_en   = accept;
   assign rd_addr = (req_item.command == tcfla_pkg::CMD_ALLOC)
                    ? chosen_head_now[tcfla_pkg::SLOT_W-1:0]
                    : tcfla_pkg::SLOT_W'(req_item.slot_to_free);

   tcfla_ram #(
      .WIDTH (tcfla_pkg::ENTRY_W),
      .DEPTH (tcfla_pkg::TOTAL_SLOTS)
   ) link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // An entry never written since reset reads as not in use with a zero link.
   assign entry_valid  = valid_ff[addr_ff];
   assign entry_link   = entry_valid ? rd_data[tcfla_pkg::LINK_W-1:0] : '0;
   assign entry_in_use = entry_valid && rd_data[tcfla_pkg::LINK_W];

   assign use_large     = req_ff.request_size > small_limit_ff;
   assign limit         = use_large ? large_limit_ff : small_limit_ff;
   assign head          = use_large ? large_head_ff : small_head_ff;
   assign slot_in_range = 32'(req_ff.slot_to_free) < tcfla_pkg::TOTAL_SLOTS;
   assign slot_is_large = 32'(req_ff.slot_to_free) >= tcfla_pkg::SMALL_SLOTS;

   always_comb begin
      state_in       = state_ff;
      small_limit_in = small_limit_ff;
      large_limit_in = large_limit_ff;
      small_head_in  = small_head_ff;
      large_head_in  = large_head_ff;
      alloc_head_in  = alloc_head_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      req_in         = req_ff;
      addr_in        = addr_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_data        = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            tcfla_pkg::CSR_SMALL_LIMIT: small_limit_in = csr_wdata;
            tcfla_pkg::CSR_LARGE_LIMIT: large_limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in  = req_item;
               addr_in = rd_addr;
               if (req_item.command == tcfla_pkg::CMD_INIT) begin
                  count_in = '0;
                  state_in = S_INIT;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            rsp_in.status = tcfla_pkg::ST_OK;
            state_in      = S_IDLE;
            case (req_ff.command)
               tcfla_pkg::CMD_ALLOC: begin
                  rsp_in.from_large_pool = use_large;
                  if (req_ff.request_size >= limit) begin
                     rsp_in.status = tcfla_pkg::ST_TOO_LARGE;
                  end else if (head >= tcfla_pkg::NIL_LINK) begin
                     rsp_in.status = tcfla_pkg::ST_EMPTY;
                  end else begin
                     // Pop the head, mark it in use and push it onto the allocated list.
                     if (use_large) begin
                        large_head_in = entry_link;
                     end else begin
                        small_head_in = entry_link;
                     end
                     wr_en                = 1'b1;
                     wr_data              = {1'b1, alloc_head_ff};
                     alloc_head_in        = head;
                     rsp_in.granted_slot  = 8'(head);
                  end
               end
               tcfla_pkg::CMD_FREE: begin
                  if (!slot_in_range) begin
                     rsp_in.status = tcfla_pkg::ST_RANGE;
                  end else begin
                     rsp_in.from_large_pool = slot_is_large;
                     // A slot that is not in use is left alone so the lists stay intact.
                     if (entry_in_use) begin
                        wr_en = 1'b1;
                        if (slot_is_large) begin
                           wr_data       = {1'b0, large_head_ff};
                           large_head_in = tcfla_pkg::LINK_W'(req_ff.slot_to_free);
                        end else begin
                           wr_data       = {1'b0, small_head_ff};
                           small_head_in = tcfla_pkg::LINK_W'(req_ff.slot_to_free);
                        end
                     end
                  end
               end
               default: ;
            endcase
         end

         S_INIT: begin
            // Each slot links to the one below it, except the lowest of each pool.
            wr_en   = 1'b1;
            wr_addr = count_ff;
            if ((count_ff == '0) ||
                (count_ff == tcfla_pkg::SLOT_W'(tcfla_pkg::SMALL_SLOTS))) begin
               wr_data = {1'b0, tcfla_pkg::NIL_LINK};
            end else begin
               wr_data = {1'b0, tcfla_pkg::LINK_W'(count_ff) - tcfla_pkg::LINK_W'(1)};
            end
            if (count_ff == tcfla_pkg::SLOT_W'(tcfla_pkg::TOTAL_SLOTS - 1)) begin
               small_head_in = tcfla_pkg::LINK_W'(tcfla_pkg::SMALL_SLOTS - 1);
               large_head_in = tcfla_pkg::LINK_W'(tcfla_pkg::TOTAL_SLOTS - 1);
               alloc_head_in = tcfla_pkg::NIL_LINK;
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rsp_in.status = tcfla_pkg::ST_OK;
               state_in      = S_IDLE;
            end else begin
               count_in = count_ff + tcfla_pkg::SLOT_W'(1);
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         small_limit_ff <= tcfla_pkg::SMALL_LIMIT_RESET;
         large_limit_ff <= tcfla_pkg::LARGE_LIMIT_RESET;
         small_head_ff  <= tcfla_pkg::NIL_LINK;
         large_head_ff  <= tcfla_pkg::NIL_LINK;
         alloc_head_ff  <= tcfla_pkg::NIL_LINK;
         valid_ff       <= '0;
         count_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         small_limit_ff <= small_limit_in;
         large_limit_ff <= large_limit_in;
         small_head_ff  <= small_head_in;
         large_head_ff  <= large_head_in;
         alloc_head_ff  <= alloc_head_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      req_ff  <= req_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### src/tcfla_ram.sv
module tcfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/tb_two_class_free_list_allocator.sv
`timescale 1ns / 100ps

module tb_two_class_free_list_allocator;
   import tcfla_pkg::*;

   // The fourth command code has no name in the package; the block answers it and changes nothing.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_write_enable;
   logic csr_index;
   logic [LIMIT_W-1:0] csr_wdata;

   two_class_free_list_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the allocator: link store, in-use marks, list heads and limits.
   logic [LINK_W-1:0]  link_mem [TOTAL_SLOTS];
   bit                 slot_taken [TOTAL_SLOTS];
   logic [LINK_W-1:0]  small_head;
   logic [LINK_W-1:0]  large_head;
   logic [LINK_W-1:0]  taken_head;
   logic [LIMIT_W-1:0] small_lim;
   logic [LIMIT_W-1:0] large_lim;

   rsp_type awaited_rsp [$];
   int failures = 0;

   function automatic rsp_type apply_command(req_type item);
      rsp_type outcome;
      logic use_large;
      logic [LIMIT_W-1:0] cap;
      logic [LINK_W-1:0] pick;
      int slot;
      outcome = '0;
      case (item.command)
         CMD_INIT: begin
            small_head = NIL_LINK;
            large_head = NIL_LINK;
            taken_head = NIL_LINK;
            // Slots are pushed in ascending order, so each pool's highest slot ends on top.
            for (int i = 0; i < TOTAL_SLOTS; i++) begin
               slot_taken[i] = 1'b0;
               if (i < SMALL_SLOTS) begin
                  link_mem[i] = small_head;
                  small_head = LINK_W'(i);
               end else begin
                  link_mem[i] = large_head;
                  large_head = LINK_W'(i);
               end
            end
         end
         CMD_ALLOC: begin
            use_large = item.request_size > small_lim;
            cap = use_large ? large_lim : small_lim;
            outcome.from_large_pool = use_large;
            if (item.request_size >= cap) begin
               outcome.status = ST_TOO_LARGE;
            end else if ((use_large ? large_head : small_head) >= NIL_LINK) begin
               outcome.status = ST_EMPTY;
            end else begin
               pick = use_large ? large_head : small_head;
               if (use_large) begin
                  large_head = link_mem[pick];
               end else begin
                  small_head = link_mem[pick];
               end
               slot_taken[pick] = 1'b1;
               link_mem[pick] = taken_head;
               taken_head = pick;
               outcome.granted_slot = 8'(pick);
            end
         end
         CMD_FREE: begin
            slot = int'(item.slot_to_free);
            if (slot >= TOTAL_SLOTS) begin
               outcome.status = ST_RANGE;
            end else begin
               outcome.from_large_pool = (slot >= SMALL_SLOTS);
               // A slot that is not in use is ignored so the free lists stay intact.
               if (slot_taken[slot]) begin
                  slot_taken[slot] = 1'b0;
                  if (slot >= SMALL_SLOTS) begin
                     link_mem[slot] = large_head;
                     large_head = LINK_W'(slot);
                  end else begin
                     link_mem[slot] = small_head;
                     small_head = LINK_W'(slot);
                  end
               end
            end
         end
         default: ;
      endcase
      return outcome;
   endfunction

   function automatic req_type mk(logic [1:0] command, logic [LIMIT_W-1:0] size,
                                  logic [7:0] slot);
      req_type item;
      item.command = command;
      item.request_size = size;
      item.slot_to_free = slot;
      return item;
   endfunction

   // Sizes are aimed at the current limits: fits in each pool, the exact boundaries, and noise.
   function automatic logic [LIMIT_W-1:0] pick_size(int small_pct);
      int lo_s;
      int hi_l;
      int roll;
      lo_s = int'(small_lim);
      hi_l = int'(large_lim);
      roll = $urandom_range(0, 99);
      if (roll < small_pct && lo_s > 0) return LIMIT_W'($urandom_range(0, lo_s - 1));
      roll = $urandom_range(0, 9);
      if (roll < 6 && hi_l > lo_s + 1) return LIMIT_W'($urandom_range(lo_s + 1, hi_l - 1));
      if (roll == 6) return small_lim;
      if (roll == 7) return large_lim;
      if (roll == 8) return small_lim + 1'b1;
      return LIMIT_W'($urandom);
   endfunction

   function automatic req_type next_traffic_item(int alloc_pct, int small_pct);
      req_type item;
      int roll;
      int start_at;
      int idx;
      item.command = CMD_ALLOC;
      item.request_size = LIMIT_W'($urandom);
      item.slot_to_free = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
         item.command = CMD_INIT;
      end else if (roll < 3) begin
         item.command = CMD_UNUSED;
      end else if ($urandom_range(0, 99) < alloc_pct) begin
         item.request_size = pick_size(small_pct);
      end else begin
         item.command = CMD_FREE;
         // Mostly hand back a slot that is really in use; otherwise keep the random one.
         if ($urandom_range(0, 99) < 85) begin
            start_at = $urandom_range(0, TOTAL_SLOTS - 1);
            for (int k = 0; k < TOTAL_SLOTS; k++) begin
               idx = (start_at + k) % TOTAL_SLOTS;
               if (slot_taken[idx]) begin
                  item.slot_to_free = 8'(idx);
                  break;
               end
            end
         end
      end
      return item;
   endfunction

   task automatic send_item(req_type item);
      @(negedge clock);
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_rsp.push_back(apply_command(item));
   endtask

   task automatic idle_gap();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (roll < 70) n = 0;
      else if (roll < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      int guard;
      @(negedge clock);
      start <= 1'b0;
      guard = 0;
      while ((awaited_rsp.size() != 0 || busy !== 1'b0) && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= 5000) begin
         $error("timed out waiting for %0d outstanding results", awaited_rsp.size());
         failures++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic index, logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_SMALL_LIMIT) small_lim = value;
      else large_lim = value;
   endtask

   task automatic set_limits(logic [LIMIT_W-1:0] small_value, logic [LIMIT_W-1:0] large_value);
      wait_idle();
      write_limit(CSR_SMALL_LIMIT, small_value);
      write_limit(CSR_LARGE_LIMIT, large_value);
   endtask

   task automatic run_traffic(int count, int alloc_pct, int small_pct, bit with_gaps);
      req_type item;
      int sent;
      sent = 0;
      while (sent < count) begin
         item = next_traffic_item(alloc_pct, small_pct);
         send_item(item);
         if (item.command != CMD_UNUSED) sent++;
         if (with_gaps) idle_gap();
      end
   endtask

   // Before any init the pools are empty and nothing is in use; reset limits apply.
   task automatic test_before_init();
      send_item(mk(CMD_ALLOC, 16'd5, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd100, 8'hFF));
      send_item(mk(CMD_ALLOC, 16'd32, 8'd0));
      send_item(mk(CMD_ALLOC, 16'hFFFF, 8'hFF));
      send_item(mk(CMD_FREE, 16'd0, 8'd7));
      send_item(mk(CMD_FREE, 16'hFFFF, 8'hFF));
      send_item(mk(CMD_UNUSED, 16'd0, 8'd0));
   endtask

   task automatic test_grant_and_return();
      send_item(mk(CMD_INIT, 16'hFFFF, 8'hFF));
      send_item(mk(CMD_ALLOC, 16'd0, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd31, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd33, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd255, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd256, 8'd0));
      send_item(mk(CMD_FREE, 16'd0, 8'd255));
      send_item(mk(CMD_FREE, 16'd0, 8'd255));
      send_item(mk(CMD_FREE, 16'd0, 8'd0));
      send_item(mk(CMD_ALLOC, 16'd100, 8'd0));
      send_item(mk(CMD_FREE, 16'hFFFF, 8'd239));
      send_item(mk(CMD_ALLOC, 16'd1, 8'hFF));
      send_item(mk(CMD_UNUSED, 16'hFFFF, 8'hFF));
   endtask

   task automatic test_limit_extremes();
      set_limits(16'd1, 16'd1);
      send_item(mk(CMD_INIT, 16'd0, 8'd0));
      run_traffic(200, 60, 50, 1'b1);
      set_limits(16'hFFFF, 16'hFFFF);
      run_traffic(200, 70, 50, 1'b1);
      set_limits(16'd1, 16'hFFFF);
      send_item(mk(CMD_INIT, 16'd0, 8'd0));
      run_traffic(200, 70, 30, 1'b0);
      set_limits(16'hFFFF, 16'd1);
      run_traffic(200, 50, 50, 1'b1);
   endtask

   task automatic test_mixed_traffic();
      set_limits(SMALL_LIMIT_RESET, LARGE_LIMIT_RESET);
      send_item(mk(CMD_INIT, 16'd0, 8'd0));
      // Allocation-heavy and back to back, so the small pool runs dry.
      run_traffic(400, 92, 85, 1'b0);
      run_traffic(250, 25, 60, 1'b1);
      set_limits(LIMIT_W'($urandom_range(1, 65535)), LIMIT_W'($urandom_range(1, 65535)));
      run_traffic(250, 60, 50, 1'b1);
      set_limits(16'd100, 16'd2000);
      send_item(mk(CMD_INIT, 16'd0, 8'd0));
      run_traffic(200, 55, 40, 1'b1);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_item);
            failures++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_item.status);
               failures++;
            end
            if (rsp_item.granted_slot !== want.granted_slot) begin
               $error("granted_slot mismatch: expected %0d, got %0d",
                      want.granted_slot, rsp_item.granted_slot);
               failures++;
            end
            if (rsp_item.from_large_pool !== want.from_large_pool) begin
               $error("from_large_pool mismatch: expected %0d, got %0d",
                      want.from_large_pool, rsp_item.from_large_pool);
               failures++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_SMALL_LIMIT;
      csr_wdata = '0;
      small_head = NIL_LINK;
      large_head = NIL_LINK;
      taken_head = NIL_LINK;
      small_lim = SMALL_LIMIT_RESET;
      large_lim = LARGE_LIMIT_RESET;
      for (int i = 0; i < TOTAL_SLOTS; i++) slot_taken[i] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_init();
      test_grant_and_return();
      test_limit_extremes();
      test_mixed_traffic();

      wait_idle();
      if (awaited_rsp.size() != 0) failures++;
      if (failures == 0) begin
         $display("two_class_free_list_allocator verification clean");
      end else begin
         $display("two_class_free_list_allocator verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("two_class_free_list_allocator verification failed");
      $finish;
   end

endmodule
